// File: hw/rtl/jmse_pkg.sv
package jmse_pkg;

  // Data path width of the shift word and the reset sequence length.
  localparam int DataWidth   = 32;
  localparam int LenWidth    = $clog2(DataWidth) + 1;
  localparam int ResetCycles = 5;

  // Command codes carried in the op field.
  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_RESET    = 3'd1;
  localparam logic [2:0] OP_IDLE     = 3'd2;
  localparam logic [2:0] OP_SHIFT_IR = 3'd3;
  localparam logic [2:0] OP_SHIFT_DR = 3'd4;
  localparam logic [2:0] OP_RUN      = 3'd5;

  // Result status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_NO_JOB = 2'd2;

  // Tracked TAP states, with one merged set of IR and DR states.
  localparam logic [3:0] TAP_UNKNOWN = 4'd0;
  localparam logic [3:0] TAP_RESET   = 4'd1;
  localparam logic [3:0] TAP_IDLE    = 4'd2;
  localparam logic [3:0] TAP_SEL_DR  = 4'd3;
  localparam logic [3:0] TAP_SEL_IR  = 4'd4;
  localparam logic [3:0] TAP_CAPTURE = 4'd5;
  localparam logic [3:0] TAP_SHIFT   = 4'd6;
  localparam logic [3:0] TAP_EXIT1   = 4'd7;
  localparam logic [3:0] TAP_PAUSE   = 4'd8;
  localparam logic [3:0] TAP_EXIT2   = 4'd9;
  localparam logic [3:0] TAP_UPDATE  = 4'd10;

  // Class of an item as sorted by the front end.
  typedef enum logic [1:0] {
    ClsTick,
    ClsCmd,
    ClsNop
  } cls_e;

  // One classified item as it travels through the queue.
  typedef struct packed {
    cls_e                  cls;
    logic [2:0]            op;
    logic                  tdo;
    logic [DataWidth-1:0]  value;
    logic [LenWidth-1:0]   len;
    logic [9:0]            header;
    logic [9:0]            trailer;
    logic [15:0]           idle;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic                  tck;
    logic                  tms;
    logic                  tdi;
    logic [DataWidth-1:0]  word;
    logic                  done;
    logic [1:0]            status;
    logic [3:0]            tap;
  } res_t;

  // TAP transition table with the merged state numbering.
  function automatic logic [3:0] tap_next(input logic [3:0] s, input logic tms);
    logic [3:0] n;
    unique case (s)
      TAP_RESET:   n = tms ? TAP_RESET   : TAP_IDLE;
      TAP_IDLE:    n = tms ? TAP_SEL_DR  : TAP_IDLE;
      TAP_SEL_DR:  n = tms ? TAP_SEL_IR  : TAP_CAPTURE;
      TAP_SEL_IR:  n = tms ? TAP_RESET   : TAP_CAPTURE;
      TAP_CAPTURE: n = tms ? TAP_EXIT1   : TAP_SHIFT;
      TAP_SHIFT:   n = tms ? TAP_EXIT1   : TAP_SHIFT;
      TAP_EXIT1:   n = tms ? TAP_UPDATE  : TAP_PAUSE;
      TAP_PAUSE:   n = tms ? TAP_EXIT2   : TAP_PAUSE;
      TAP_EXIT2:   n = tms ? TAP_UPDATE  : TAP_SHIFT;
      TAP_UPDATE:  n = tms ? TAP_SEL_DR  : TAP_IDLE;
      default:     n = TAP_UNKNOWN;
    endcase
    return n;
  endfunction

endpackage

// File: hw/rtl/jmse_front.sv
module jmse_front (
  input  logic [79:0]     s_tdata_i,
  input  logic [2:0]      s_tuser_i,
  output jmse_pkg::cmd_t  cmd_o
);

  logic [jmse_pkg::LenWidth-1:0]  len_raw;
  logic [jmse_pkg::LenWidth-1:0]  len_c;
  logic [jmse_pkg::LenWidth-1:0]  shamt;
  logic [jmse_pkg::DataWidth-1:0] mask;

  // Clamp the length into one to the data width and mask the value to it.
  assign len_raw = s_tdata_i[38:33];

  always_comb begin
    if (len_raw == '0) begin
      len_c = jmse_pkg::LenWidth'(1);
    end else if (len_raw > jmse_pkg::LenWidth'(jmse_pkg::DataWidth)) begin
      len_c = jmse_pkg::LenWidth'(jmse_pkg::DataWidth);
    end else begin
      len_c = len_raw;
    end
  end

  assign shamt = jmse_pkg::LenWidth'(jmse_pkg::DataWidth) - len_c;
  assign mask  = {jmse_pkg::DataWidth{1'b1}} >> shamt;

  // Sort the item into tick, command or ignored code.
  always_comb begin
    cmd_o.op      = s_tuser_i;
    cmd_o.tdo     = s_tdata_i[0];
    cmd_o.value   = s_tdata_i[32:1] & mask;
    cmd_o.len     = len_c;
    cmd_o.header  = s_tdata_i[48:39];
    cmd_o.trailer = s_tdata_i[58:49];
    cmd_o.idle    = s_tdata_i[74:59];
    unique case (s_tuser_i)
      jmse_pkg::OP_TICK: begin
        cmd_o.cls = jmse_pkg::ClsTick;
      end
      jmse_pkg::OP_RESET, jmse_pkg::OP_IDLE, jmse_pkg::OP_SHIFT_IR,
      jmse_pkg::OP_SHIFT_DR, jmse_pkg::OP_RUN: begin
        cmd_o.cls = jmse_pkg::ClsCmd;
      end
      default: begin
        cmd_o.cls = jmse_pkg::ClsNop;
      end
    endcase
  end

endmodule

// File: hw/rtl/jmse_queue.sv
module jmse_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  jmse_pkg::cmd_t  push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output jmse_pkg::cmd_t  pop_data_o
);

  jmse_pkg::cmd_t mem_q [2];
  logic [1:0]     count_q, count_d;
  logic           wr_ptr_q, rd_ptr_q;
  logic           push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: hw/rtl/jmse_back.sv
module jmse_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  output logic            q_ready_o,
  input  jmse_pkg::cmd_t  q_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output jmse_pkg::res_t  out_data_o
);

  // Job phase codes.
  localparam logic [3:0] PH_RESET   = 4'd0;
  localparam logic [3:0] PH_NAV     = 4'd1;
  localparam logic [3:0] PH_CAPTURE = 4'd2;
  localparam logic [3:0] PH_ENTER   = 4'd3;
  localparam logic [3:0] PH_HEADER  = 4'd4;
  localparam logic [3:0] PH_DATA    = 4'd5;
  localparam logic [3:0] PH_TRAILER = 4'd6;
  localparam logic [3:0] PH_UPDATE  = 4'd7;
  localparam logic [3:0] PH_RUN     = 4'd8;

  logic [3:0]                     tap_q, tap_d;
  logic [2:0]                     kind_q, kind_d;
  logic [3:0]                     phase_q, phase_d;
  logic [15:0]                    cnt_q, cnt_d;
  logic [jmse_pkg::DataWidth-1:0] sr_q, sr_d;
  logic [jmse_pkg::LenWidth-1:0]  len_q, len_d;
  logic [9:0]                     hdr_q, hdr_d;
  logic [9:0]                     trl_q, trl_d;
  logic [15:0]                    idle_q, idle_d;
  jmse_pkg::res_t                 res;
  jmse_pkg::res_t                 out_q;
  logic                           out_valid_q;
  logic                           pop;

  function automatic logic is_shift(input logic [2:0] k);
    return (k == jmse_pkg::OP_SHIFT_IR) || (k == jmse_pkg::OP_SHIFT_DR);
  endfunction

  function automatic logic [3:0] nav_target(input logic [2:0] k);
    logic [3:0] t;
    if (k == jmse_pkg::OP_SHIFT_IR) begin
      t = jmse_pkg::TAP_SEL_IR;
    end else if (k == jmse_pkg::OP_SHIFT_DR) begin
      t = jmse_pkg::TAP_SEL_DR;
    end else begin
      t = jmse_pkg::TAP_IDLE;
    end
    return t;
  endfunction

  // First phase of a job that starts from the given TAP state.
  function automatic logic [3:0] route_phase(input logic [3:0] s, input logic [2:0] k);
    logic [3:0] p;
    if (s == jmse_pkg::TAP_UNKNOWN || s > jmse_pkg::TAP_UPDATE) begin
      p = PH_RESET;
    end else if (is_shift(k) && s == nav_target(k)) begin
      p = PH_CAPTURE;
    end else begin
      p = PH_NAV;
    end
    return p;
  endfunction

  // TMS level that steps toward the job's target state.
  function automatic logic nav_tms(input logic [3:0] s, input logic [2:0] k);
    logic t;
    if (nav_target(k) == jmse_pkg::TAP_IDLE) begin
      t = (s == jmse_pkg::TAP_CAPTURE) || (s == jmse_pkg::TAP_SHIFT) ||
          (s == jmse_pkg::TAP_PAUSE) || (s == jmse_pkg::TAP_EXIT1) ||
          (s == jmse_pkg::TAP_EXIT2);
    end else begin
      t = (s != jmse_pkg::TAP_RESET);
    end
    return t;
  endfunction

  // A queued item is taken whenever the output register is free or drains.
  assign pop       = q_valid_i && (!out_valid_q || out_ready_i);
  assign q_ready_o = !out_valid_q || out_ready_i;

  // One item step: the job sequencer and the TAP tracker.
  always_comb begin
    logic [15:0]                   cnt_n;
    logic                          last;
    logic [jmse_pkg::LenWidth-1:0] sh;

    tap_d   = tap_q;
    kind_d  = kind_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    sr_d    = sr_q;
    len_d   = len_q;
    hdr_d   = hdr_q;
    trl_d   = trl_q;
    idle_d  = idle_q;

    res        = '0;
    cnt_n      = cnt_q + 16'd1;
    last       = (cnt_n >= 16'(len_q));
    sh         = len_q - jmse_pkg::LenWidth'(1);

    if (pop) begin
      case (q_data_i.cls)
        jmse_pkg::ClsCmd: begin
          if (kind_q != 3'd0) begin
            res.status = jmse_pkg::ST_REJECT;
          end else begin
            len_d  = q_data_i.len;
            sr_d   = q_data_i.value;
            hdr_d  = q_data_i.header;
            trl_d  = q_data_i.trailer;
            idle_d = q_data_i.idle;
            kind_d = q_data_i.op;
            cnt_d  = 16'd0;
            if (q_data_i.op == jmse_pkg::OP_RESET) begin
              phase_d = PH_RESET;
            end else begin
              phase_d = route_phase(tap_q, q_data_i.op);
            end
          end
        end
        jmse_pkg::ClsTick: begin
          if (kind_q == 3'd0) begin
            res.status = jmse_pkg::ST_NO_JOB;
          end else begin
            res.tck = 1'b1;
            unique case (phase_q)
              PH_RESET: begin
                res.tms = 1'b1;
                cnt_d   = cnt_n;
                if (cnt_n >= 16'(jmse_pkg::ResetCycles)) begin
                  tap_d = jmse_pkg::TAP_RESET;
                  if (kind_q == jmse_pkg::OP_RESET) begin
                    res.done = 1'b1;
                  end else begin
                    phase_d = route_phase(jmse_pkg::TAP_RESET, kind_q);
                    cnt_d   = 16'd0;
                  end
                end
              end
              PH_NAV: begin
                res.tms = nav_tms(tap_q, kind_q);
                tap_d   = jmse_pkg::tap_next(tap_q, res.tms);
                if (tap_d == nav_target(kind_q)) begin
                  if (is_shift(kind_q)) begin
                    phase_d = PH_CAPTURE;
                  end else if (kind_q == jmse_pkg::OP_RUN && idle_q != 16'd0) begin
                    phase_d = PH_RUN;
                    cnt_d   = idle_q;
                  end else begin
                    res.done = 1'b1;
                  end
                end
              end
              PH_CAPTURE: begin
                tap_d   = jmse_pkg::tap_next(tap_q, 1'b0);
                phase_d = PH_ENTER;
              end
              PH_ENTER: begin
                tap_d   = jmse_pkg::tap_next(tap_q, 1'b0);
                cnt_d   = 16'd0;
                phase_d = (hdr_q != 10'd0) ? PH_HEADER : PH_DATA;
              end
              PH_HEADER: begin
                res.tdi = 1'b1;
                tap_d   = jmse_pkg::tap_next(tap_q, 1'b0);
                cnt_d   = cnt_n;
                if (cnt_n >= 16'(hdr_q)) begin
                  cnt_d   = 16'd0;
                  phase_d = PH_DATA;
                end
              end
              PH_DATA: begin
                // Rotate one data bit out and the sampled TDO bit in at the top.
                res.tdi = sr_q[0];
                res.tms = last && (trl_q == 10'd0);
                sr_d    = (sr_q >> 1) |
                          (jmse_pkg::DataWidth'(q_data_i.tdo) << sh);
                tap_d   = jmse_pkg::tap_next(tap_q, res.tms);
                cnt_d   = cnt_n;
                if (last) begin
                  cnt_d   = 16'd0;
                  phase_d = (trl_q != 10'd0) ? PH_TRAILER : PH_UPDATE;
                end
              end
              PH_TRAILER: begin
                res.tdi = 1'b1;
                res.tms = (cnt_n >= 16'(trl_q));
                tap_d   = jmse_pkg::tap_next(tap_q, res.tms);
                cnt_d   = cnt_n;
                if (res.tms) begin
                  phase_d = PH_UPDATE;
                end
              end
              PH_UPDATE: begin
                res.tdi  = 1'b1;
                res.tms  = 1'b1;
                tap_d    = jmse_pkg::tap_next(tap_q, 1'b1);
                res.word = sr_q;
                res.done = 1'b1;
              end
              PH_RUN: begin
                tap_d = jmse_pkg::tap_next(tap_q, 1'b0);
                if (cnt_q != 16'd0) begin
                  cnt_d = cnt_q - 16'd1;
                end
                if (cnt_d == 16'd0) begin
                  res.done = 1'b1;
                end
              end
              default: begin
                res.tck  = 1'b0;
                res.done = 1'b1;
              end
            endcase
            if (res.done) begin
              kind_d  = 3'd0;
              phase_d = PH_RESET;
              cnt_d   = 16'd0;
            end
          end
        end
        default: begin
          // Unused op codes pass through with no effect.
        end
      endcase
    end
    res.tap = tap_d;
  end

  // Job state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q   <= jmse_pkg::TAP_UNKNOWN;
      kind_q  <= 3'd0;
      phase_q <= PH_RESET;
      cnt_q   <= 16'd0;
      sr_q    <= '0;
      len_q   <= '0;
      hdr_q   <= 10'd0;
      trl_q   <= 10'd0;
      idle_q  <= 16'd0;
    end else begin
      tap_q   <= tap_d;
      kind_q  <= kind_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      sr_q    <= sr_d;
      len_q   <= len_d;
      hdr_q   <= hdr_d;
      trl_q   <= trl_d;
      idle_q  <= idle_d;
    end
  end

  // Output register that holds a result until its transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // With no job the sequencer sits in its rest phase with a clear counter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (kind_q == 3'd0) |-> (phase_q == PH_RESET && cnt_q == 16'd0))
    else $error("idle job with stale phase or counter");

  // A finished job frees the engine for the next command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && res.done) |=> (kind_q == 3'd0))
    else $error("job still busy after done");

  // A rejected command leaves the TAP and job untouched.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && res.status == jmse_pkg::ST_REJECT) |=> ($stable(tap_q) && $stable(kind_q)))
    else $error("rejected command changed state");

  // A driven TCK cycle always reports an ok status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.tck) |-> (out_q.status == jmse_pkg::ST_OK))
    else $error("tck cycle with error status");
`endif

endmodule

// File: hw/rtl/jtag_master_shift_engine.sv
// JTAG master shift engine. Each input transfer is a command (reset, go idle, shift IR,
// shift DR, run test) or a TCK tick, and each one yields exactly one result transfer.
// A tick during a job drives one TCK cycle with its TMS and TDI levels and feeds in the TDO level
// sampled during that cycle; the tick that finishes a job sets tlast and, for a shift,
// returns the captured word. The engine takes one transfer per clock while the output side
// accepts results: a decoder feeds a two-entry queue, and the execution unit handles one queued
// item per clock into an output register, which holds a result until it is taken. The job
// sequencer updates its state in that single step, which sets the rate.
module jtag_master_shift_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: tdo_level[0], shift_value[32:1], shift_length[38:33], header_bits[48:39],
  // trailer_bits[58:49], idle_cycles[74:59], zero fill above.
  input  logic [79:0] s_axis_tdata_i,
  // tuser: op[2:0].
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: tck_pulse[0], tms_out[1], tdi_out[2], captured_word[34:3], tap_now[38:35],
  // zero fill above.
  output logic [39:0] m_axis_tdata_o,
  // tlast: job_done.
  output logic        m_axis_tlast_o,
  // tuser: status[1:0].
  output logic [1:0]  m_axis_tuser_o
);

  jmse_pkg::cmd_t front_cmd;
  jmse_pkg::cmd_t queue_cmd;
  jmse_pkg::res_t result;
  logic           queue_valid;
  logic           queue_ready;

  // Decode and sort each input transfer.
  jmse_front u_front (
    .s_tdata_i (s_axis_tdata_i),
    .s_tuser_i (s_axis_tuser_i),
    .cmd_o     (front_cmd)
  );

  // Queue between the decoder and the execution unit.
  jmse_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (s_axis_tvalid_i),
    .push_ready_o (s_axis_tready_o),
    .push_data_i  (front_cmd),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready),
    .pop_data_o   (queue_cmd)
  );

  // Job sequencer, TAP tracker and output register.
  jmse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (queue_valid),
    .q_ready_o   (queue_ready),
    .q_data_i    (queue_cmd),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (result)
  );

  // Pack the result fields onto the output stream.
  assign m_axis_tdata_o = {1'b0, result.tap, result.word, result.tdi, result.tms, result.tck};
  assign m_axis_tlast_o = result.done;
  assign m_axis_tuser_o = result.status;

endmodule

// File: test/tb_jtag_master_shift_engine.sv
`timescale 1ns / 1ps

module tb_jtag_master_shift_engine;

  // Spare op codes that the engine must pass through untouched.
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  // A job kind of zero means that no job is running.
  localparam logic [2:0] JOB_NONE  = jmse_pkg::OP_TICK;

  localparam logic [31:0] ALL_ONES   = '1;
  localparam int          CYCLE_CAP  = 8_000_000;
  localparam int          ITEM_GOAL  = 1500;
  localparam int          QUIET_FROM = 1250;
  localparam int          NUM_ROWS   = 21;

  // Steps of a job, as the engine walks through them.
  typedef enum logic [3:0] {
    PhReset,
    PhNav,
    PhCapture,
    PhEnter,
    PhHeader,
    PhData,
    PhTrailer,
    PhUpdate,
    PhRun
  } job_step_e;

  typedef struct packed {
    logic [2:0]  op;
    logic        tdo;
    logic [31:0] value;
    logic [5:0]  len;
    logic [9:0]  header;
    logic [9:0]  trailer;
    logic [15:0] idle;
  } jtag_item_t;

  typedef struct packed {
    logic        tck;
    logic        tms;
    logic        tdi;
    logic [31:0] word;
    logic        done;
    logic [1:0]  status;
    logic [3:0]  tap;
  } tck_result_t;

  typedef struct packed {
    jtag_item_t  item;
    logic        drain;
    logic        typed;
    tck_result_t want;
  } plan_row_t;

  localparam tck_result_t NO_CHECK = '0;

  // Directed rows. A row with drain set is followed by ticks until its job ends.
  // A job never ends in a select state, so the shortcut from select straight into
  // capture cannot be reached from the ports.
  plan_row_t plan [NUM_ROWS] = '{
    '{'{jmse_pkg::OP_TICK, 1'b1, 32'hFFFF_FFFF, 6'd63, 10'd1023, 10'd1023, 16'hFFFF},
      1'b0, 1'b1,
      '{1'b0, 1'b0, 1'b0, 32'd0, 1'b0, jmse_pkg::ST_NO_JOB, jmse_pkg::TAP_UNKNOWN}},
    '{'{OP_SPARE6, 1'b1, 32'hFFFF_FFFF, 6'd63, 10'd1023, 10'd1023, 16'hFFFF}, 1'b0, 1'b1,
      '{1'b0, 1'b0, 1'b0, 32'd0, 1'b0, jmse_pkg::ST_OK, jmse_pkg::TAP_UNKNOWN}},
    '{'{OP_SPARE7, 1'b0, 32'd0, 6'd0, 10'd0, 10'd0, 16'd0}, 1'b0, 1'b1,
      '{1'b0, 1'b0, 1'b0, 32'd0, 1'b0, jmse_pkg::ST_OK, jmse_pkg::TAP_UNKNOWN}},
    '{'{jmse_pkg::OP_IDLE, 1'b0, 32'd0, 6'd0, 10'd0, 10'd0, 16'd0}, 1'b1, 1'b0, NO_CHECK},
    '{'{jmse_pkg::OP_RUN, 1'b0, 32'd0, 6'd0, 10'd0, 10'd0, 16'd0}, 1'b1, 1'b0, NO_CHECK},
    '{'{jmse_pkg::OP_RESET, 1'b1, 32'd0, 6'd1, 10'd0, 10'd0, 16'd0}, 1'b0, 1'b1,
      '{1'b0, 1'b0, 1'b0, 32'd0, 1'b0, jmse_pkg::ST_OK, jmse_pkg::TAP_IDLE}},
    '{'{jmse_pkg::OP_RESET, 1'b0, 32'd0, 6'd1, 10'd0, 10'd0, 16'd0}, 1'b1, 1'b1,
      '{1'b0, 1'b0, 1'b0, 32'd0, 1'b0, jmse_pkg::ST_REJECT, jmse_pkg::TAP_IDLE}},
    '{'{jmse_pkg::OP_SHIFT_IR, 1'b0, 32'hFFFF_FFFF, 6'd32, 10'd0, 10'd0, 16'd0},
      1'b1, 1'b0, NO_CHECK},
    '{'{jmse_pkg::OP_SHIFT_IR, 1'b0, 32'd0, 6'd1, 10'd0, 10'd3, 16'd0},
      1'b1, 1'b0, NO_CHECK},
    '{'{jmse_pkg::OP_SHIFT_DR, 1'b0, 32'hFFFF_FFFF, 6'd0, 10'd100, 10'd70, 16'd0},
      1'b1, 1'b0, NO_CHECK},
    '{'{jmse_pkg::OP_SHIFT_DR, 1'b0, 32'hA5A5_5A5A, 6'd63, 10'd1, 10'd1, 16'd0},
      1'b1, 1'b0, NO_CHECK},
    '{'{jmse_pkg::OP_SHIFT_DR, 1'b0, 32'h15, 6'd5, 10'd0, 10'd0, 16'd0},
      1'b0, 1'b0, NO_CHECK},
    '{'{jmse_pkg::OP_RUN, 1'b0, 32'd0, 6'd1, 10'd0, 10'd0, 16'd3}, 1'b1, 1'b1,
      '{1'b0, 1'b0, 1'b0, 32'd0, 1'b0, jmse_pkg::ST_REJECT, jmse_pkg::TAP_UPDATE}},
    '{'{jmse_pkg::OP_IDLE, 1'b0, 32'd0, 6'd1, 10'd0, 10'd0, 16'd0}, 1'b1, 1'b0, NO_CHECK},
    '{'{jmse_pkg::OP_IDLE, 1'b0, 32'd0, 6'd1, 10'd0, 10'd0, 16'd0}, 1'b1, 1'b0, NO_CHECK},
    '{'{jmse_pkg::OP_RUN, 1'b0, 32'd0, 6'd1, 10'd0, 10'd0, 16'd1}, 1'b1, 1'b0, NO_CHECK},
    '{'{jmse_pkg::OP_RUN, 1'b0, 32'd0, 6'd1, 10'd0, 10'd0, 16'd120}, 1'b1, 1'b0, NO_CHECK},
    '{'{jmse_pkg::OP_RESET, 1'b0, 32'd0, 6'd1, 10'd0, 10'd0, 16'd0}, 1'b1, 1'b0, NO_CHECK},
    '{'{jmse_pkg::OP_SHIFT_DR, 1'b0, 32'hBEEF, 6'd16, 10'd2, 10'd0, 16'd0},
      1'b1, 1'b0, NO_CHECK},
    '{'{jmse_pkg::OP_TICK, 1'b0, 32'd0, 6'd1, 10'd0, 10'd0, 16'd0}, 1'b0, 1'b1,
      '{1'b0, 1'b0, 1'b0, 32'd0, 1'b0, jmse_pkg::ST_NO_JOB, jmse_pkg::TAP_UPDATE}},
    '{'{jmse_pkg::OP_RUN, 1'b0, 32'd0, 6'd1, 10'd0, 10'd0, 16'd3}, 1'b1, 1'b0, NO_CHECK}
  };

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        s_valid = 1'b0;
  logic [79:0] s_data  = '0;
  logic [2:0]  s_user  = jmse_pkg::OP_TICK;
  logic        rx_ready = 1'b0;
  logic        s_ready;
  logic        m_valid;
  logic [39:0] m_data;
  logic        m_last;
  logic [1:0]  m_user;

  // Engine state as the predictor tracks it.
  logic [3:0]  trk_tap   = jmse_pkg::TAP_UNKNOWN;
  logic [2:0]  job_op    = JOB_NONE;
  job_step_e   job_step  = PhReset;
  logic [15:0] step_cnt  = '0;
  logic [31:0] data_sr   = '0;
  logic [5:0]  data_len  = '0;
  logic [9:0]  pad_head  = '0;
  logic [9:0]  pad_tail  = '0;
  logic [15:0] run_len   = '0;

  tck_result_t pending_cycles [$];
  int          errors    = 0;
  int          counted   = 0;
  int          cycles    = 0;
  int          gap_pct   = 0;
  int          stall_pct = 0;
  int          rx_span   = 0;
  int          rx_hold   = 0;
  bit          quiet     = 1'b0;

  jtag_master_shift_engine dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(rx_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tlast_o (m_last),
    .m_axis_tuser_o (m_user)
  );

  // Free-running clock, 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // TAP transition for one TCK cycle with the merged IR and DR states.
  function automatic logic [3:0] tap_after(input logic [3:0] s, input logic tms);
    logic [3:0] on_zero;
    logic [3:0] on_one;
    on_zero = jmse_pkg::TAP_UNKNOWN;
    on_one  = jmse_pkg::TAP_UNKNOWN;
    case (s)
      jmse_pkg::TAP_RESET: begin
        on_zero = jmse_pkg::TAP_IDLE;
        on_one  = jmse_pkg::TAP_RESET;
      end
      jmse_pkg::TAP_IDLE: begin
        on_zero = jmse_pkg::TAP_IDLE;
        on_one  = jmse_pkg::TAP_SEL_DR;
      end
      jmse_pkg::TAP_SEL_DR: begin
        on_zero = jmse_pkg::TAP_CAPTURE;
        on_one  = jmse_pkg::TAP_SEL_IR;
      end
      jmse_pkg::TAP_SEL_IR: begin
        on_zero = jmse_pkg::TAP_CAPTURE;
        on_one  = jmse_pkg::TAP_RESET;
      end
      jmse_pkg::TAP_CAPTURE: begin
        on_zero = jmse_pkg::TAP_SHIFT;
        on_one  = jmse_pkg::TAP_EXIT1;
      end
      jmse_pkg::TAP_SHIFT: begin
        on_zero = jmse_pkg::TAP_SHIFT;
        on_one  = jmse_pkg::TAP_EXIT1;
      end
      jmse_pkg::TAP_EXIT1: begin
        on_zero = jmse_pkg::TAP_PAUSE;
        on_one  = jmse_pkg::TAP_UPDATE;
      end
      jmse_pkg::TAP_PAUSE: begin
        on_zero = jmse_pkg::TAP_PAUSE;
        on_one  = jmse_pkg::TAP_EXIT2;
      end
      jmse_pkg::TAP_EXIT2: begin
        on_zero = jmse_pkg::TAP_SHIFT;
        on_one  = jmse_pkg::TAP_UPDATE;
      end
      jmse_pkg::TAP_UPDATE: begin
        on_zero = jmse_pkg::TAP_IDLE;
        on_one  = jmse_pkg::TAP_SEL_DR;
      end
      default: ;
    endcase
    return tms ? on_one : on_zero;
  endfunction

  function automatic logic is_shift_job();
    return job_op == jmse_pkg::OP_SHIFT_IR || job_op == jmse_pkg::OP_SHIFT_DR;
  endfunction

  // State the navigation step heads for: the select state of a shift, else idle.
  function automatic logic [3:0] route_goal();
    if (job_op == jmse_pkg::OP_SHIFT_IR) return jmse_pkg::TAP_SEL_IR;
    if (job_op == jmse_pkg::OP_SHIFT_DR) return jmse_pkg::TAP_SEL_DR;
    return jmse_pkg::TAP_IDLE;
  endfunction

  function automatic logic route_tms();
    if (route_goal() == jmse_pkg::TAP_IDLE)
      return trk_tap inside {jmse_pkg::TAP_CAPTURE, jmse_pkg::TAP_SHIFT, jmse_pkg::TAP_PAUSE,
                             jmse_pkg::TAP_EXIT1, jmse_pkg::TAP_EXIT2};
    return trk_tap != jmse_pkg::TAP_RESET;
  endfunction

  function automatic void start_route();
    step_cnt = '0;
    if (trk_tap == jmse_pkg::TAP_UNKNOWN || trk_tap > jmse_pkg::TAP_UPDATE) begin
      job_step = PhReset;
    end else if (is_shift_job() && trk_tap == route_goal()) begin
      job_step = PhCapture;
    end else begin
      job_step = PhNav;
    end
  endfunction

  // Result of one input transfer; updates the tracked engine state.
  function automatic tck_result_t predict_result(input jtag_item_t it);
    tck_result_t r;
    logic [5:0]  n;
    logic        fin;
    logic        last;
    r   = '0;
    fin = 1'b0;
    if (it.op != jmse_pkg::OP_TICK) begin
      if (it.op > jmse_pkg::OP_RUN) begin
        // Spare codes change nothing.
      end else if (job_op != JOB_NONE) begin
        r.status = jmse_pkg::ST_REJECT;
      end else begin
        n = it.len;
        if (n == '0) n = 6'd1;
        if (int'(n) > jmse_pkg::DataWidth) n = 6'(jmse_pkg::DataWidth);
        data_len = n;
        data_sr  = it.value & (ALL_ONES >> (jmse_pkg::DataWidth - int'(n)));
        pad_head = it.header;
        pad_tail = it.trailer;
        run_len  = it.idle;
        job_op   = it.op;
        if (it.op == jmse_pkg::OP_RESET) begin
          job_step = PhReset;
          step_cnt = '0;
        end else begin
          start_route();
        end
      end
    end else if (job_op == JOB_NONE) begin
      r.status = jmse_pkg::ST_NO_JOB;
    end else begin
      r.tck = 1'b1;
      case (job_step)
        PhReset: begin
          r.tms    = 1'b1;
          step_cnt = step_cnt + 16'd1;
          if (step_cnt >= 16'(jmse_pkg::ResetCycles)) begin
            trk_tap = jmse_pkg::TAP_RESET;
            if (job_op == jmse_pkg::OP_RESET) fin = 1'b1;
            else start_route();
          end
        end
        PhNav: begin
          r.tms   = route_tms();
          trk_tap = tap_after(trk_tap, r.tms);
          if (trk_tap == route_goal()) begin
            if (is_shift_job()) begin
              job_step = PhCapture;
            end else if (job_op == jmse_pkg::OP_RUN && run_len != '0) begin
              job_step = PhRun;
              step_cnt = run_len;
            end else begin
              fin = 1'b1;
            end
          end
        end
        PhCapture: begin
          trk_tap  = tap_after(trk_tap, 1'b0);
          job_step = PhEnter;
        end
        PhEnter: begin
          trk_tap  = tap_after(trk_tap, 1'b0);
          step_cnt = '0;
          job_step = (pad_head != '0) ? PhHeader : PhData;
        end
        PhHeader: begin
          r.tdi    = 1'b1;
          trk_tap  = tap_after(trk_tap, 1'b0);
          step_cnt = step_cnt + 16'd1;
          if (step_cnt >= 16'(pad_head)) begin
            step_cnt = '0;
            job_step = PhData;
          end
        end
        PhData: begin
          // Data leaves at bit 0 while TDO enters at the top of the used length.
          last     = int'(step_cnt) + 1 >= int'(data_len);
          r.tdi    = data_sr[0];
          r.tms    = last && pad_tail == '0;
          data_sr  = (data_sr >> 1) | (32'(it.tdo) << (data_len - 6'd1));
          trk_tap  = tap_after(trk_tap, r.tms);
          step_cnt = step_cnt + 16'd1;
          if (last) begin
            step_cnt = '0;
            job_step = (pad_tail != '0) ? PhTrailer : PhUpdate;
          end
        end
        PhTrailer: begin
          r.tdi    = 1'b1;
          r.tms    = int'(step_cnt) + 1 >= int'(pad_tail);
          trk_tap  = tap_after(trk_tap, r.tms);
          step_cnt = step_cnt + 16'd1;
          if (r.tms) job_step = PhUpdate;
        end
        PhUpdate: begin
          r.tdi   = 1'b1;
          r.tms   = 1'b1;
          trk_tap = tap_after(trk_tap, 1'b1);
          r.word  = data_sr;
          fin     = 1'b1;
        end
        PhRun: begin
          trk_tap = tap_after(trk_tap, 1'b0);
          if (step_cnt != '0) step_cnt = step_cnt - 16'd1;
          if (step_cnt == '0) fin = 1'b1;
        end
        default: begin
          r.tck = 1'b0;
          fin   = 1'b1;
        end
      endcase
    end
    if (fin) begin
      r.done   = 1'b1;
      job_op   = JOB_NONE;
      job_step = PhReset;
      step_cnt = '0;
    end
    r.tap = trk_tap;
    return r;
  endfunction

  // Input fields with sizes kept small most of the time.
  function automatic jtag_item_t random_fields(input logic [2:0] op);
    jtag_item_t it;
    it.op      = op;
    it.tdo     = 1'($urandom_range(0, 1));
    it.value   = $urandom;
    it.len     = 6'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
                                                : $urandom_range(1, 32));
    it.header  = 10'(($urandom_range(0, 24) == 0) ? $urandom_range(0, 1023)
                                                  : $urandom_range(0, 3));
    it.trailer = 10'(($urandom_range(0, 24) == 0) ? $urandom_range(0, 1023)
                                                  : $urandom_range(0, 3));
    it.idle    = 16'(($urandom_range(0, 24) == 0) ? $urandom_range(0, 1023)
                                                  : $urandom_range(0, 6));
    return it;
  endfunction

  // Drive one transfer and queue its expected result; may idle afterwards.
  task automatic send_item(input jtag_item_t it, input logic typed, input tck_result_t want);
    tck_result_t predicted;
    predicted = predict_result(it);
    pending_cycles.push_back(typed ? want : predicted);
    if (it.op <= jmse_pkg::OP_RUN) counted++;
    s_valid <= 1'b1;
    s_data  <= {5'd0, it.idle, it.trailer, it.header, it.len, it.value, it.tdo};
    s_user  <= it.op;
    do @(posedge clk_i); while (!s_ready);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  // Stray transfer: a random command, rejected while a job runs, or a spare code.
  task automatic send_noise();
    jtag_item_t it;
    if ($urandom_range(0, 1) == 0)
      it = random_fields(3'($urandom_range(32'(jmse_pkg::OP_RESET), 32'(jmse_pkg::OP_RUN))));
    else
      it = random_fields($urandom_range(0, 1) ? OP_SPARE7 : OP_SPARE6);
    send_item(it, 1'b0, NO_CHECK);
  endtask

  // Tick until the running job ends, with stray transfers mixed in when asked.
  task automatic drain_job(input logic noisy);
    while (job_op != JOB_NONE) begin
      if (noisy && $urandom_range(0, 15) == 0) send_noise();
      send_item(random_fields(jmse_pkg::OP_TICK), 1'b0, NO_CHECK);
    end
  endtask

  // Hold the input side until every queued result has come back.
  task automatic wait_drained();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (pending_cycles.size() != 0);
  endtask

  // Result side: ready drops in bursts, with calm stretches in between.
  always @(posedge clk_i) begin
    if (rx_span == 0) begin
      rx_span <= 300;
      case ($urandom_range(0, 2))
        0:       stall_pct <= 0;
        1:       stall_pct <= 4;
        default: stall_pct <= 20;
      endcase
    end else begin
      rx_span <= rx_span - 1;
    end
    if (rx_hold != 0) begin
      rx_hold  <= rx_hold - 1;
      rx_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
      rx_hold  <= $urandom_range(0, 10);
      rx_ready <= 1'b0;
    end else begin
      rx_ready <= 1'b1;
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endfunction

  // Compare every result transfer with the oldest pending expectation.
  always @(posedge clk_i) begin : watch_results
    tck_result_t seen;
    tck_result_t want;
    if (rst_ni && m_valid && rx_ready) begin
      seen.tck    = m_data[0];
      seen.tms    = m_data[1];
      seen.tdi    = m_data[2];
      seen.word   = m_data[34:3];
      seen.tap    = m_data[38:35];
      seen.done   = m_last;
      seen.status = m_user;
      if (pending_cycles.size() == 0) begin
        $error("result transfer with nothing pending");
        errors++;
      end else begin
        want = pending_cycles.pop_front();
        check_field("tck_pulse", 32'(want.tck), 32'(seen.tck));
        check_field("tms_out", 32'(want.tms), 32'(seen.tms));
        check_field("tdi_out", 32'(want.tdi), 32'(seen.tdi));
        check_field("captured_word", want.word, seen.word);
        check_field("job_done", 32'(want.done), 32'(seen.done));
        check_field("status", 32'(want.status), 32'(seen.status));
        check_field("tap_now", 32'(want.tap), 32'(seen.tap));
      end
    end
  end

  // Reset, directed rows, then random jobs.
  initial begin
    jtag_item_t it;
    int         row;
    int         jobs;
    int         pick;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    gap_pct = 10;
    for (row = 0; row < NUM_ROWS; row++) begin
      send_item(plan[row].item, plan[row].typed, plan[row].want);
      if (plan[row].drain) drain_job(1'b0);
    end

    jobs = 0;
    while (counted < ITEM_GOAL) begin
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 4;
        default: gap_pct = 20;
      endcase
      if (counted >= QUIET_FROM) quiet = 1'b1;
      if (jobs % 20 == 5) wait_drained();
      // Now and then a tick with no job, a spare code or a stray command between jobs.
      if ($urandom_range(0, 7) == 0) begin
        if ($urandom_range(0, 1) == 0) begin
          send_item(random_fields(jmse_pkg::OP_TICK), 1'b0, NO_CHECK);
        end else begin
          send_noise();
        end
      end
      pick = $urandom_range(0, 99);
      if (pick < 35)      it = random_fields(jmse_pkg::OP_SHIFT_DR);
      else if (pick < 60) it = random_fields(jmse_pkg::OP_SHIFT_IR);
      else if (pick < 75) it = random_fields(jmse_pkg::OP_RUN);
      else if (pick < 87) it = random_fields(jmse_pkg::OP_IDLE);
      else                it = random_fields(jmse_pkg::OP_RESET);
      send_item(it, 1'b0, NO_CHECK);
      drain_job(1'b1);
      jobs++;
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
